FILE: rtl/core/stas_pkg.sv
// Shared types and constants for the switch-triggered altitude sequencer.
// No dependencies; every other file in rtl/core uses it by scoped names.
package stas_pkg;

  // Sequencer phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_ASCEND  = 2'd1;
  localparam logic [1:0] PH_HOLD    = 2'd2;
  localparam logic [1:0] PH_DESCEND = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_CHANNEL = 2'd1;
  localparam logic [1:0] CFG_CLIMB   = 2'd2;

  // Switch channel codes
  localparam logic [3:0] CH_AUX1     = 4'd5;
  localparam logic [3:0] CH_AUX2     = 4'd6;
  localparam logic [3:0] CH_AUX2_ALT = 4'd7;
  localparam logic [3:0] CH_AUX3     = 4'd8;
  localparam logic [3:0] CH_AUX4     = 4'd9;
  localparam logic [3:0] CH_AUX5     = 4'd10;
  localparam logic [3:0] CH_AUX6     = 4'd11;

  // Switch thresholds in Q1.15 (+0.5 / -0.5)
  localparam logic signed [15:0] AUX_HIGH_RAW = 16'sd16384;
  localparam logic signed [15:0] AUX_LOW_RAW  = -16'sd16384;

  // Arrival window and altitude floor, at the 25-bit difference width
  localparam logic signed [24:0] ARRIVE_TOL_MM = 25'sd300;
  localparam logic signed [24:0] ALT_MIN       = -25'sd8388608;

  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 32;

  typedef struct packed {
    logic               stick_valid;
    logic               is_armed;
    logic               nav_offboard;
    logic               altitude_valid;
    logic signed [23:0] altitude_mm;
    logic signed [15:0] aux_one;
    logic signed [15:0] aux_two;
    logic signed [15:0] aux_three;
    logic signed [15:0] aux_four;
    logic signed [15:0] aux_five;
    logic signed [15:0] aux_six;
  } item_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } sw_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic signed [23:0] home_altitude;
    logic signed [23:0] target_altitude;
    logic               armed_before;
    logic               offboard_before;
    logic               high_before;
    logic               low_before;
  } state_t;

  typedef struct packed {
    logic               setpoint_active;
    logic signed [23:0] target_altitude_mm;
    logic               request_offboard;
    logic [1:0]         mode;
  } res_t;

endpackage

FILE: rtl/core/stas_aux_sel.sv
// Switch channel select and threshold compare.
// Depends on stas_pkg.
module stas_aux_sel (
  input  logic [3:0]     channel,
  input  stas_pkg::item_t item,
  output stas_pkg::sw_t  sw
);

  logic signed [15:0] aux;

  always_comb begin
    unique case (channel) inside
      stas_pkg::CH_AUX1: aux = item.aux_one;
      stas_pkg::CH_AUX2, stas_pkg::CH_AUX2_ALT: aux = item.aux_two;
      stas_pkg::CH_AUX3: aux = item.aux_three;
      stas_pkg::CH_AUX4: aux = item.aux_four;
      stas_pkg::CH_AUX5: aux = item.aux_five;
      stas_pkg::CH_AUX6: aux = item.aux_six;
      default: aux = item.aux_two;
    endcase
  end

  assign sw.hi = (aux > stas_pkg::AUX_HIGH_RAW);
  assign sw.lo = (aux < stas_pkg::AUX_LOW_RAW);

endmodule

FILE: rtl/core/stas_step.sv
// Next-state and result logic for one control tick.
// Depends on stas_pkg; fed by stas_aux_sel.
module stas_step (
  input  logic             enable,
  input  logic [15:0]      climb_delta_mm,
  input  stas_pkg::item_t  item,
  input  stas_pkg::sw_t    sw,
  input  stas_pkg::state_t st,
  output stas_pkg::state_t nxt,
  output stas_pkg::res_t   res
);

  logic signed [24:0] z_ext;
  logic signed [24:0] climb;
  logic signed [24:0] diff;
  logic               arrived;
  logic               rising;
  logic               falling;
  logic               active;

  assign z_ext   = {item.altitude_mm[23], item.altitude_mm};
  assign climb   = z_ext - $signed({9'd0, climb_delta_mm});
  assign diff    = z_ext - {st.target_altitude[23], st.target_altitude};
  assign arrived = (diff > -stas_pkg::ARRIVE_TOL_MM) && (diff < stas_pkg::ARRIVE_TOL_MM);
  assign rising  = sw.hi && !st.high_before;
  assign falling = sw.lo && !st.low_before;

  always_comb begin
    nxt    = st;
    active = 1'b0;
    if (enable && item.stick_valid) begin
      // drop back to idle on a disarm edge
      if (!item.is_armed && st.armed_before) begin
        nxt.phase           = stas_pkg::PH_IDLE;
        nxt.home_altitude   = '0;
        nxt.target_altitude = '0;
      end
      nxt.armed_before = item.is_armed;
      if (item.is_armed) begin
        nxt.offboard_before = item.nav_offboard;
        if (st.phase != stas_pkg::PH_IDLE && !item.nav_offboard && st.offboard_before) begin
          nxt.phase           = stas_pkg::PH_IDLE;
          nxt.home_altitude   = '0;
          nxt.target_altitude = '0;
        end else if (item.altitude_valid) begin
          nxt.high_before = sw.hi;
          nxt.low_before  = sw.lo;
          unique case (st.phase)
            stas_pkg::PH_IDLE: begin
              if (rising) begin
                nxt.home_altitude   = item.altitude_mm;
                nxt.target_altitude = (climb < stas_pkg::ALT_MIN) ?
                                      stas_pkg::ALT_MIN[23:0] : climb[23:0];
                nxt.phase           = stas_pkg::PH_ASCEND;
              end
            end
            stas_pkg::PH_ASCEND: begin
              if (arrived) begin
                nxt.phase = stas_pkg::PH_HOLD;
              end
            end
            stas_pkg::PH_HOLD: begin
              if (falling) begin
                nxt.target_altitude = st.home_altitude;
                nxt.phase           = stas_pkg::PH_DESCEND;
              end
            end
            default: begin
              if (arrived) begin
                nxt.phase           = stas_pkg::PH_IDLE;
                nxt.home_altitude   = '0;
                nxt.target_altitude = '0;
              end
            end
          endcase
          active = (nxt.phase != stas_pkg::PH_IDLE);
        end
      end
    end
  end

  assign res.setpoint_active    = active;
  assign res.target_altitude_mm = active ? nxt.target_altitude : '0;
  assign res.request_offboard   = active && !item.nav_offboard;
  assign res.mode               = nxt.phase;

endmodule

FILE: rtl/core/switch_triggered_altitude_sequencer.sv
// Top level of the switch-triggered altitude sequencer: ports, registers, assertions.
// Depends on stas_pkg, stas_aux_sel and stas_step.
//
// Usage:
//   One control tick enters as one transfer on the in_ stream channel and
//   yields exactly one result transfer on the out_ channel, in order.
//   A tick lands in an input register, the sequencer state and the result
//   are computed in one pass of shallow logic (channel mux, one 25-bit
//   subtract for the climb target, one for the arrival window), and the
//   result lands in the output register.
//   Throughput: 1 tick per cycle while out_tready is high; the state
//   update is a single registered pass, so each tick sees the state left
//   by the one before it.
//   Stall: when out_tready is low the output register holds its result and
//   the input register holds the next tick; in_tready drops only when both
//   are full, so up to two ticks are buffered.
//   Configuration: cfg_ other channel is always ready; index 0 enable,
//   1 switch_channel, 2 climb_delta_mm; other indexes are ignored. Write it
//   only while no tick is in flight.
//   Reset (rst_n low, synchronous): pipeline emptied, sequencer idle with
//   home and target zero, edge history cleared, enable 1, channel 6,
//   climb delta 1000 mm.
module switch_triggered_altitude_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: stick_valid[0], is_armed[1], nav_offboard[2], altitude_valid[3],
  //   altitude_mm[27:4], aux_one[43:28], aux_two[59:44], aux_three[75:60],
  //   aux_four[91:76], aux_five[107:92], aux_six[123:108], zero [127:124]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [stas_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata: setpoint_active[0], target_altitude_mm[24:1],
  //   request_offboard[25], mode[27:26], zero [31:28]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stas_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);

  // configuration registers
  logic        enable_r;
  logic [3:0]  channel_r;
  logic [15:0] climb_r;

  // input register
  logic            in_valid_r;
  stas_pkg::item_t item_r;
  stas_pkg::item_t item_in;

  // sequencer state
  stas_pkg::state_t state_r;
  stas_pkg::state_t state_nxt;

  // output register
  logic           out_valid_r;
  stas_pkg::res_t res_r;
  stas_pkg::res_t res_nxt;

  stas_pkg::sw_t sw;
  logic          advance;
  logic          in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b1;
      channel_r <= stas_pkg::CH_AUX2;
      climb_r   <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        stas_pkg::CFG_ENABLE:  enable_r  <= cfg_data[0];
        stas_pkg::CFG_CHANNEL: channel_r <= cfg_data[3:0];
        stas_pkg::CFG_CLIMB:   climb_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input transfer
  assign item_in.stick_valid    = in_tdata[0];
  assign item_in.is_armed       = in_tdata[1];
  assign item_in.nav_offboard   = in_tdata[2];
  assign item_in.altitude_valid = in_tdata[3];
  assign item_in.altitude_mm    = in_tdata[27:4];
  assign item_in.aux_one        = in_tdata[43:28];
  assign item_in.aux_two        = in_tdata[59:44];
  assign item_in.aux_three      = in_tdata[75:60];
  assign item_in.aux_four       = in_tdata[91:76];
  assign item_in.aux_five       = in_tdata[107:92];
  assign item_in.aux_six        = in_tdata[123:108];

  // advance the tick into the output register when that register is free or being read out
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_in;
    end
  end

  stas_aux_sel u_aux_sel (
    .channel (channel_r),
    .item    (item_r),
    .sw      (sw)
  );

  stas_step u_step (
    .enable         (enable_r),
    .climb_delta_mm (climb_r),
    .item           (item_r),
    .sw             (sw),
    .st             (state_r),
    .nxt            (state_nxt),
    .res            (res_nxt)
  );

  // commit state only as the tick's result is taken into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: stas_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.mode, res_r.request_offboard,
                       res_r.target_altitude_mm, res_r.setpoint_active};

`ifndef ASSERT_OFF
  // idle always carries a zeroed home and target
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == stas_pkg::PH_IDLE) |->
      (state_r.home_altitude == '0 && state_r.target_altitude == '0))
    else $error("idle phase with nonzero home or target");

  // idle can only move to ascending
  a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == stas_pkg::PH_IDLE) |=>
      (state_r.phase == stas_pkg::PH_IDLE || state_r.phase == stas_pkg::PH_ASCEND))
    else $error("idle left to a phase other than ascending");

  // a disabled sequencer freezes its state
  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !enable_r) |=> $stable(state_r))
    else $error("state changed while disabled");

  // an issued setpoint always comes with a non-idle mode
  a_active_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.setpoint_active) |-> (res_r.mode != stas_pkg::PH_IDLE))
    else $error("setpoint issued in idle mode");
`endif

endmodule

FILE: bench/stas_tick_checker.sv
`timescale 1ns / 100ps
// Checker for the switch-triggered altitude sequencer: watches the in_, out_ and cfg_
// channels, predicts one result per tick and compares. Depends on stas_pkg.
module stas_tick_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [stas_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [stas_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [15:0]                     cfg_data,
  output int unsigned                     pending,
  output int unsigned                     fail_count
);

  localparam int unsigned PRINT_CAP = 100;

  logic              en_q;
  logic [3:0]        chan_q;
  logic [15:0]       climb_q;
  stas_pkg::state_t  st;
  stas_pkg::res_t    tick_results[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    // keep the log short on a badly broken block
    if (fail_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void park();
    st.phase           = stas_pkg::PH_IDLE;
    st.home_altitude   = '0;
    st.target_altitude = '0;
  endfunction

  function automatic logic near_target(input logic signed [23:0] alt);
    int d;
    d = int'(alt) - int'(st.target_altitude);
    if (d < 0) d = -d;
    return d < int'(stas_pkg::ARRIVE_TOL_MM);
  endfunction

  function automatic stas_pkg::res_t predict_tick(input stas_pkg::item_t t);
    stas_pkg::res_t     r;
    logic signed [15:0] sw;
    logic               hi, lo, rise, fall;
    int                 tgt;
    r = '0;
    if (en_q && t.stick_valid) begin
      if (!t.is_armed && st.armed_before) park();
      st.armed_before = t.is_armed;
      if (t.is_armed) begin
        if (st.phase != stas_pkg::PH_IDLE && !t.nav_offboard && st.offboard_before) begin
          park();
          st.offboard_before = 1'b0;
        end else begin
          st.offboard_before = t.nav_offboard;
          if (t.altitude_valid) begin
            case (chan_q)
              stas_pkg::CH_AUX1: sw = t.aux_one;
              stas_pkg::CH_AUX3: sw = t.aux_three;
              stas_pkg::CH_AUX4: sw = t.aux_four;
              stas_pkg::CH_AUX5: sw = t.aux_five;
              stas_pkg::CH_AUX6: sw = t.aux_six;
              default: sw = t.aux_two;
            endcase
            hi   = sw > stas_pkg::AUX_HIGH_RAW;
            lo   = sw < stas_pkg::AUX_LOW_RAW;
            rise = hi && !st.high_before;
            fall = lo && !st.low_before;
            st.high_before = hi;
            st.low_before  = lo;
            case (st.phase)
              stas_pkg::PH_IDLE: if (rise) begin
                tgt = int'(t.altitude_mm) - int'(climb_q);
                if (tgt < int'(stas_pkg::ALT_MIN)) tgt = int'(stas_pkg::ALT_MIN);
                st.home_altitude   = t.altitude_mm;
                st.target_altitude = 24'(tgt);
                st.phase           = stas_pkg::PH_ASCEND;
              end
              stas_pkg::PH_ASCEND: if (near_target(t.altitude_mm)) st.phase = stas_pkg::PH_HOLD;
              stas_pkg::PH_HOLD: if (fall) begin
                st.target_altitude = st.home_altitude;
                st.phase           = stas_pkg::PH_DESCEND;
              end
              default: if (near_target(t.altitude_mm)) park();
            endcase
            r.setpoint_active = st.phase != stas_pkg::PH_IDLE;
          end
        end
      end
    end
    if (r.setpoint_active) r.target_altitude_mm = st.target_altitude;
    r.request_offboard = r.setpoint_active && !t.nav_offboard;
    r.mode             = st.phase;
    return r;
  endfunction

  always @(posedge clk) begin
    stas_pkg::res_t  got, want;
    stas_pkg::item_t t;
    if (!rst_n) begin
      en_q       = 1'b1;
      chan_q     = stas_pkg::CH_AUX2;
      climb_q    = 16'd1000;
      fail_count = 0;
      park();
      st.armed_before    = 1'b0;
      st.offboard_before = 1'b0;
      st.high_before     = 1'b0;
      st.low_before      = 1'b0;
      tick_results.delete();
    end else begin
      // retire the oldest expectation first; a tick accepted at this edge
      // cannot have its result out yet
      if (out_tvalid && out_tready) begin
        got.setpoint_active    = out_tdata[0];
        got.target_altitude_mm = out_tdata[24:1];
        got.request_offboard   = out_tdata[25];
        got.mode               = out_tdata[27:26];
        if (tick_results.size() == 0) begin
          report_mismatch("unexpected result, raw data", int'(out_tdata), 0);
        end else begin
          want = tick_results.pop_front();
          if (got.setpoint_active != want.setpoint_active)
            report_mismatch("setpoint_active", got.setpoint_active, want.setpoint_active);
          if (got.target_altitude_mm != want.target_altitude_mm)
            report_mismatch("target_altitude_mm", int'(got.target_altitude_mm),
                            int'(want.target_altitude_mm));
          if (got.request_offboard != want.request_offboard)
            report_mismatch("request_offboard", got.request_offboard, want.request_offboard);
          if (got.mode != want.mode)
            report_mismatch("mode", got.mode, want.mode);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          stas_pkg::CFG_ENABLE:  en_q    = cfg_data[0];
          stas_pkg::CFG_CHANNEL: chan_q  = cfg_data[3:0];
          stas_pkg::CFG_CLIMB:   climb_q = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        t.stick_valid    = in_tdata[0];
        t.is_armed       = in_tdata[1];
        t.nav_offboard   = in_tdata[2];
        t.altitude_valid = in_tdata[3];
        t.altitude_mm    = in_tdata[27:4];
        t.aux_one        = in_tdata[43:28];
        t.aux_two        = in_tdata[59:44];
        t.aux_three      = in_tdata[75:60];
        t.aux_four       = in_tdata[91:76];
        t.aux_five       = in_tdata[107:92];
        t.aux_six        = in_tdata[123:108];
        tick_results.push_back(predict_tick(t));
      end
    end
    pending = tick_results.size();
  end

endmodule

FILE: bench/switch_triggered_altitude_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the switch-triggered altitude sequencer: clock, reset, stimulus and
// verdict. Depends on stas_pkg, the sequencer RTL and stas_tick_checker.
module switch_triggered_altitude_sequencer_tb;

  // Tick flag bits as packed at the bottom of in_tdata
  localparam logic [3:0] F_STICK = 4'b0001;
  localparam logic [3:0] F_ARM   = 4'b0010;
  localparam logic [3:0] F_OFFB  = 4'b0100;
  localparam logic [3:0] F_ALT   = 4'b1000;
  localparam logic [3:0] F_FLY   = 4'b1111;

  localparam int TICKS        = 650;   // ticks to send in total
  localparam int CALM_FROM    = 580;   // no idling on either side after this many
  localparam int STALL_LIMIT  = 1000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 4;     // settle time after the last result is back
  localparam int ALT_LO       = -8388608;
  localparam int ALT_HI       = 8388607;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [stas_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [stas_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [1:0]                      cfg_index;
  logic [15:0]                     cfg_data;

  int unsigned pending;
  int unsigned fail_count;

  // Stimulus-side view of the configuration, used to place the switch value and aim the flights
  logic [3:0]  chan  = stas_pkg::CH_AUX2;
  logic [15:0] climb = 16'd1000;
  logic [3:0]  fly_flags = F_FLY;
  logic        quiet = 1'b0;
  int          sent = 0;
  int          idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  switch_triggered_altitude_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  stas_tick_checker tick_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Watchdog: count cycles in which no channel moves a transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall in random bursts, never once calm
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Aux value: mostly random, now and then a full-scale extreme
  function automatic logic signed [15:0] pick_aux();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic int sw_high();
    return $urandom_range(16385, 32767);
  endfunction

  function automatic int sw_low();
    return -int'($urandom_range(16385, 32768));
  endfunction

  function automatic int sw_mid();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Offset around an arrival point, sometimes exactly on the window edge
  function automatic int near_off();
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 300 : -300;
    return int'($urandom_range(0, 598)) - 299;
  endfunction

  // Build one tick: clamp the altitude, fill the aux slots at random and put
  // the switch value in the slot the current channel selects
  function automatic stas_pkg::item_t make_tick(input logic [3:0] flags, input int alt,
                                                input int sw);
    stas_pkg::item_t t;
    int              a;
    a = (alt < ALT_LO) ? ALT_LO : ((alt > ALT_HI) ? ALT_HI : alt);
    t.stick_valid    = flags[0];
    t.is_armed       = flags[1];
    t.nav_offboard   = flags[2];
    t.altitude_valid = flags[3];
    t.altitude_mm    = 24'(a);
    t.aux_one        = pick_aux();
    t.aux_two        = pick_aux();
    t.aux_three      = pick_aux();
    t.aux_four       = pick_aux();
    t.aux_five       = pick_aux();
    t.aux_six        = pick_aux();
    case (chan)
      stas_pkg::CH_AUX1: t.aux_one   = 16'(sw);
      stas_pkg::CH_AUX3: t.aux_three = 16'(sw);
      stas_pkg::CH_AUX4: t.aux_four  = 16'(sw);
      stas_pkg::CH_AUX5: t.aux_five  = 16'(sw);
      stas_pkg::CH_AUX6: t.aux_six   = 16'(sw);
      default: t.aux_two   = 16'(sw);
    endcase
    return t;
  endfunction

  // Offer one tick, with an occasional idle burst ahead of it, and hold it
  // until the transfer completes
  task automatic send_tick(input stas_pkg::item_t t);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, t.aux_six, t.aux_five, t.aux_four, t.aux_three, t.aux_two,
                  t.aux_one, t.altitude_mm, t.altitude_valid, t.nav_offboard, t.is_armed,
                  t.stick_valid};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Flight tick with the current flags; now and then slip in a random tick first
  task automatic fly(input int alt, input int sw);
    if ($urandom_range(0, 11) == 0)
      send_tick(make_tick(4'($urandom_range(0, 15)),
                          int'($urandom_range(0, 16777215)) + ALT_LO, pick_aux()));
    send_tick(make_tick(fly_flags, alt, sw));
  endtask

  // Hold off the sender until every result is back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == stas_pkg::CFG_CHANNEL) chan = val[3:0];
    if (idx == stas_pkg::CFG_CLIMB) climb = val;
  endtask

  initial begin
    int home, tgt, n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = stas_pkg::CFG_ENABLE;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, on the reset configuration (aux2, 1000 mm climb)
    send_tick(make_tick(4'b0000, 0, 0));                 // stick invalid: ignored
    send_tick(make_tick(F_FLY, 0, 16384));               // exactly +0.5 is not high
    send_tick(make_tick(F_FLY, 0, 32767));               // rising: climb to -1000
    send_tick(make_tick(F_FLY, -500, 32767));            // still 500 mm away
    send_tick(make_tick(F_FLY & ~F_ALT, ALT_HI, -32768)); // altitude invalid
    send_tick(make_tick(F_FLY, -1299, 16385));           // inside the window: hold
    send_tick(make_tick(F_FLY, -1000, -16384));          // exactly -0.5 is not low
    send_tick(make_tick(F_FLY, -1000, -32768));          // falling: descend to home
    send_tick(make_tick(F_FLY, -300, -32768));           // 300 mm off is not there yet
    send_tick(make_tick(F_FLY, 299, 0));                 // home reached: back to idle
    send_tick(make_tick(F_FLY, 100, 32767));             // climb again
    send_tick(make_tick(F_FLY & ~F_OFFB, 100, 32767));   // offboard lost
    send_tick(make_tick(F_FLY & ~F_OFFB, 0, 0));
    send_tick(make_tick(F_FLY & ~F_OFFB, 0, 20000));     // climb outside offboard: request it
    send_tick(make_tick(F_STICK | F_OFFB | F_ALT, 0, 0)); // disarm
    send_tick(make_tick(F_STICK, 0, 32767));             // still disarmed
    send_tick(make_tick(F_FLY, ALT_LO, 0));
    send_tick(make_tick(F_FLY, ALT_LO + 8, 32767));      // climb target saturates at the floor
    send_tick(make_tick(F_FLY, ALT_HI, 32767));          // far from target
    drain();
    write_reg(stas_pkg::CFG_ENABLE, 16'd0);
    send_tick(make_tick(F_FLY, ALT_LO, -32768));         // disabled: frozen, no setpoint
    drain();
    write_reg(stas_pkg::CFG_ENABLE, 16'd1);
    write_reg(stas_pkg::CFG_CHANNEL, 16'(stas_pkg::CH_AUX1));
    write_reg(stas_pkg::CFG_CLIMB, 16'd0);
    send_tick(make_tick(F_STICK | F_OFFB | F_ALT, 0, 0)); // disarm out of the climb
    send_tick(make_tick(F_FLY, 5000, 0));
    send_tick(make_tick(F_FLY, 5000, 32767));            // zero climb: target is here
    send_tick(make_tick(F_FLY, 5000, 0));                // arrives at once
    drain();
    write_reg(stas_pkg::CFG_CHANNEL, 16'd15);
    write_reg(stas_pkg::CFG_CLIMB, 16'hffff);

    // Random part: mostly complete flights with random content, plus noise
    while (sent < TICKS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        if ($urandom_range(0, 1) == 0)
          write_reg(stas_pkg::CFG_CHANNEL, 16'($urandom_range(0, 15)));
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 5))
            0:       write_reg(stas_pkg::CFG_CLIMB, 16'd0);
            1:       write_reg(stas_pkg::CFG_CLIMB, 16'hffff);
            2:       write_reg(stas_pkg::CFG_CLIMB, 16'($urandom));
            default: write_reg(stas_pkg::CFG_CLIMB, 16'($urandom_range(0, 4000)));
          endcase
        end
        write_reg(stas_pkg::CFG_ENABLE, ($urandom_range(0, 7) != 0) ? 16'd1 : 16'd0);
      end
      fly_flags = ($urandom_range(0, 4) == 0) ? (F_FLY & ~F_OFFB) : F_FLY;
      case ($urandom_range(0, 9))
        0:       home = ALT_LO + int'($urandom_range(0, 70000));
        1:       home = ALT_HI - int'($urandom_range(0, 70000));
        default: home = int'($urandom_range(0, 400000)) - 200000;
      endcase
      tgt = home - int'(climb);
      if (tgt < ALT_LO) tgt = ALT_LO;
      n = $urandom_range(1, 5);

      // wait at home with the switch centered, then flip it up
      repeat ($urandom_range(1, 3)) fly(home, sw_mid());
      fly(home, sw_high());
      for (int k = 1; k <= n; k++)
        fly(home + (tgt - home) * k / (n + 1), $urandom_range(0, 1) ? sw_high() : sw_mid());
      // arrive, hold a while, then flip down and come back
      repeat ($urandom_range(1, 4)) fly(tgt + near_off(), sw_mid());
      fly(tgt + near_off(), sw_low());
      for (int k = 1; k <= n; k++)
        fly(tgt + (home - tgt) * k / (n + 1), $urandom_range(0, 1) ? sw_low() : sw_mid());
      fly(home + near_off(), sw_mid());
      fly(home + near_off(), sw_mid());
      if (sent >= CALM_FROM) quiet = 1'b1;
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/stas_pkg.sv
rtl/core/stas_aux_sel.sv
rtl/core/stas_step.sv
rtl/core/switch_triggered_altitude_sequencer.sv
bench/stas_tick_checker.sv
bench/switch_triggered_altitude_sequencer_tb.sv
